// ===== rtl/rotation_matrix_to_quaternion_unit_macros.svh =====
// assertion helpers for the rotation matrix to quaternion unit
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// same-cycle implication
`define RMQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmq check failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmq check failed");

`endif

// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

    localparam int DATA_W   = 16;
    localparam int FRAC_W   = 14;
    localparam int TOL_W    = 15;
    localparam int TOL_RST  = 16;
    localparam int ONE      = 1 << FRAC_W;

    localparam int TR_W     = DATA_W + 2;
    localparam int RC_W     = DATA_W + 3;
    localparam int RAD_W    = DATA_W + 1;
    localparam int NUM_W    = DATA_W + 1;
    localparam int MAG_W    = DATA_W + 1;
    localparam int PR_W     = 2 * DATA_W;
    localparam int MN_W     = PR_W + 1;
    localparam int TM_W     = MN_W + DATA_W;
    localparam int DET_W    = TM_W + 2;

    localparam int ROOT_W   = 17;
    localparam int SQ_STEPS = ROOT_W;
    localparam int SQ_VW    = 2 * ROOT_W;
    localparam int SQ_RW    = ROOT_W + 3;

    localparam int DV_NW    = MAG_W + FRAC_W + 1;
    localparam int QUO_W    = 17;
    localparam int DV_STEPS = QUO_W;
    localparam int DV_LAT   = DV_STEPS + 1;
    localparam int QS_W     = QUO_W + 1;

    localparam int FE_LAT   = 4;
    localparam int LAT      = FE_LAT + SQ_STEPS + DV_LAT;

    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_W = 2'd3
    } t_branch;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } t_mat;

    typedef struct packed {
        logic                     ident;
        logic                     degen;
        t_branch                  branch;
        logic [2:0]               sgn;
        logic [2:0][MAG_W-1:0]    mag;
    } t_side;

    typedef struct packed {
        logic                     ident;
        logic                     degen;
        t_branch                  branch;
        logic [2:0]               sgn;
        logic [ROOT_W-1:0]        root;
    } t_dside;

    function automatic logic signed [DATA_W-1:0] sat_q(input logic [QUO_W-1:0] quo,
                                                       input logic neg);
        logic signed [QS_W-1:0] v;
        logic signed [QS_W-1:0] hi;
        logic signed [QS_W-1:0] lo;
        hi = QS_W'((1 << (DATA_W - 1)) - 1);
        lo = -hi - QS_W'(1);
        v  = QS_W'({1'b0, quo});
        if (neg) begin
            v = -v;
        end
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/rmq_front.sv =====
module rmq_front (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  rmq_pkg::t_mat               i_mat,
    input  logic [rmq_pkg::TOL_W-1:0]   i_tol,
    output logic [rmq_pkg::RAD_W-1:0]   o_rad,
    output rmq_pkg::t_side              o_side
);
    import rmq_pkg::*;

    logic signed [TR_W-1:0]  trace;
    logic signed [RC_W-1:0]  rsel;
    logic signed [NUM_W-1:0] a12, a20, a01, s01, s02, s12;
    logic signed [NUM_W-1:0] nsel [3];
    t_side                   n1_side;
    logic [RAD_W-1:0]        n1_rad;

    logic signed [PR_W-1:0]   r1_p0, r1_p1, r1_p2, r1_p3, r1_p4, r1_p5;
    logic signed [DATA_W-1:0] r1_m0, r1_m1, r1_m2;
    t_side                    r1_side;
    logic [RAD_W-1:0]         r1_rad;

    logic signed [MN_W-1:0]   r2_c0, r2_c1, r2_c2;
    logic signed [DATA_W-1:0] r2_m0, r2_m1, r2_m2;
    t_side                    r2_side;
    logic [RAD_W-1:0]         r2_rad;

    logic signed [TM_W-1:0]   r3_t0, r3_t1, r3_t2;
    t_side                    r3_side;
    logic [RAD_W-1:0]         r3_rad;

    logic signed [DET_W-1:0]  det;
    logic [DET_W-1:0]         dmag;
    t_side                    n4_side;
    t_side                    r4_side;
    logic [RAD_W-1:0]         r4_rad;

    // branch choice, radicand and numerators
    always_comb begin
        trace = TR_W'(i_mat.m00) + TR_W'(i_mat.m11) + TR_W'(i_mat.m22);
        a12 = NUM_W'(i_mat.m12) - NUM_W'(i_mat.m21);
        a20 = NUM_W'(i_mat.m20) - NUM_W'(i_mat.m02);
        a01 = NUM_W'(i_mat.m01) - NUM_W'(i_mat.m10);
        s01 = NUM_W'(i_mat.m01) + NUM_W'(i_mat.m10);
        s02 = NUM_W'(i_mat.m02) + NUM_W'(i_mat.m20);
        s12 = NUM_W'(i_mat.m12) + NUM_W'(i_mat.m21);
        n1_side = '0;
        n1_side.ident = (i_mat.m00 == DATA_W'(ONE)) && (i_mat.m11 == DATA_W'(ONE)) &&
                        (i_mat.m22 == DATA_W'(ONE)) && (i_mat.m01 == '0) &&
                        (i_mat.m02 == '0) && (i_mat.m10 == '0) && (i_mat.m12 == '0) &&
                        (i_mat.m20 == '0) && (i_mat.m21 == '0);
        if (trace > 0) begin
            n1_side.branch = BR_W;
            rsel = RC_W'(trace) + RC_W'(ONE);
            nsel[0] = a12; nsel[1] = a20; nsel[2] = a01;
        end else if (i_mat.m00 > i_mat.m11 && i_mat.m00 > i_mat.m22) begin
            n1_side.branch = BR_X;
            rsel = RC_W'(ONE) + RC_W'(i_mat.m00) - RC_W'(i_mat.m11) - RC_W'(i_mat.m22);
            nsel[0] = s01; nsel[1] = s02; nsel[2] = a12;
        end else if (i_mat.m11 > i_mat.m22) begin
            n1_side.branch = BR_Y;
            rsel = RC_W'(ONE) + RC_W'(i_mat.m11) - RC_W'(i_mat.m00) - RC_W'(i_mat.m22);
            nsel[0] = s01; nsel[1] = s12; nsel[2] = a20;
        end else begin
            n1_side.branch = BR_Z;
            rsel = RC_W'(ONE) + RC_W'(i_mat.m22) - RC_W'(i_mat.m00) - RC_W'(i_mat.m11);
            nsel[0] = s02; nsel[1] = s12; nsel[2] = a01;
        end
        if (rsel < RC_W'(ONE)) begin
            rsel = RC_W'(ONE);
        end
        n1_rad = rsel[RAD_W-1:0];
        for (int k = 0; k < 3; k++) begin
            n1_side.sgn[k] = nsel[k][NUM_W-1];
            n1_side.mag[k] = nsel[k][NUM_W-1] ? MAG_W'(-nsel[k]) : MAG_W'(nsel[k]);
        end
    end

    always_comb begin
        det  = DET_W'(r3_t0) - DET_W'(r3_t1) + DET_W'(r3_t2);
        dmag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
        n4_side = r3_side;
        n4_side.degen = dmag <= DET_W'({i_tol, {(2 * FRAC_W){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p0   <= PR_W'(i_mat.m11) * PR_W'(i_mat.m22);
            r1_p1   <= PR_W'(i_mat.m12) * PR_W'(i_mat.m21);
            r1_p2   <= PR_W'(i_mat.m10) * PR_W'(i_mat.m22);
            r1_p3   <= PR_W'(i_mat.m12) * PR_W'(i_mat.m20);
            r1_p4   <= PR_W'(i_mat.m10) * PR_W'(i_mat.m21);
            r1_p5   <= PR_W'(i_mat.m11) * PR_W'(i_mat.m20);
            r1_m0   <= i_mat.m00;
            r1_m1   <= i_mat.m01;
            r1_m2   <= i_mat.m02;
            r1_side <= n1_side;
            r1_rad  <= n1_rad;

            r2_c0   <= MN_W'(r1_p0) - MN_W'(r1_p1);
            r2_c1   <= MN_W'(r1_p2) - MN_W'(r1_p3);
            r2_c2   <= MN_W'(r1_p4) - MN_W'(r1_p5);
            r2_m0   <= r1_m0;
            r2_m1   <= r1_m1;
            r2_m2   <= r1_m2;
            r2_side <= r1_side;
            r2_rad  <= r1_rad;

            r3_t0   <= TM_W'(r2_m0) * TM_W'(r2_c0);
            r3_t1   <= TM_W'(r2_m1) * TM_W'(r2_c1);
            r3_t2   <= TM_W'(r2_m2) * TM_W'(r2_c2);
            r3_side <= r2_side;
            r3_rad  <= r2_rad;

            r4_side <= n4_side;
            r4_rad  <= r3_rad;
        end
    end

    assign o_rad  = r4_rad;
    assign o_side = r4_side;

endmodule

// ===== rtl/rmq_sqrt.sv =====
module rmq_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rmq_pkg::RAD_W-1:0]    i_rad,
    output logic [rmq_pkg::ROOT_W-1:0]   o_root
);
    import rmq_pkg::*;

    logic [SQ_RW-1:0]  r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_root [SQ_STEPS];
    logic [SQ_VW-1:0]  r_val  [SQ_STEPS];
    logic [SQ_RW-1:0]  n_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] n_root [SQ_STEPS];
    logic [SQ_VW-1:0]  n_val  [SQ_STEPS];
    logic [SQ_RW-1:0]  in_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] in_root [SQ_STEPS];
    logic [SQ_VW-1:0]  in_val  [SQ_STEPS];

    // one result bit per stage
    always_comb begin
        logic [SQ_RW-1:0] sh;
        logic [SQ_RW-1:0] tst;
        logic             ge;
        in_rem[0]  = '0;
        in_root[0] = '0;
        in_val[0]  = SQ_VW'({i_rad, {(FRAC_W + 2){1'b0}}});
        for (int j = 1; j < SQ_STEPS; j++) begin
            in_rem[j]  = r_rem[j-1];
            in_root[j] = r_root[j-1];
            in_val[j]  = r_val[j-1];
        end
        for (int j = 0; j < SQ_STEPS; j++) begin
            sh  = {in_rem[j][SQ_RW-3:0], in_val[j][SQ_VW-1 -: 2]};
            tst = SQ_RW'({in_root[j], 2'b01});
            ge  = sh >= tst;
            n_rem[j]  = ge ? sh - tst : sh;
            n_root[j] = {in_root[j][ROOT_W-2:0], ge};
            n_val[j]  = {in_val[j][SQ_VW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < SQ_STEPS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_val[j]  <= n_val[j];
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

// ===== rtl/rmq_div.sv =====
module rmq_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rmq_pkg::MAG_W-1:0]    i_mag,
    input  logic [rmq_pkg::ROOT_W-1:0]   i_den,
    output logic [rmq_pkg::QUO_W-1:0]    o_quo
);
    import rmq_pkg::*;

    logic [DV_NW-1:0]  r_num;
    logic [ROOT_W-1:0] r_den0;
    logic [ROOT_W-1:0] r_rem [DV_STEPS];
    logic [QUO_W-1:0]  r_quo [DV_STEPS];
    logic [QUO_W-1:0]  r_low [DV_STEPS];
    logic [ROOT_W-1:0] r_den [DV_STEPS];
    logic [ROOT_W-1:0] n_rem [DV_STEPS];
    logic [QUO_W-1:0]  n_quo [DV_STEPS];
    logic [QUO_W-1:0]  n_low [DV_STEPS];
    logic [ROOT_W-1:0] in_rem [DV_STEPS];
    logic [QUO_W-1:0]  in_quo [DV_STEPS];
    logic [QUO_W-1:0]  in_low [DV_STEPS];
    logic [ROOT_W-1:0] in_den [DV_STEPS];

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [ROOT_W:0] sh;
        logic            ge;
        in_rem[0] = ROOT_W'(r_num[DV_NW-1:DV_STEPS]);
        in_low[0] = r_num[DV_STEPS-1:0];
        in_quo[0] = '0;
        in_den[0] = r_den0;
        for (int j = 1; j < DV_STEPS; j++) begin
            in_rem[j] = r_rem[j-1];
            in_low[j] = r_low[j-1];
            in_quo[j] = r_quo[j-1];
            in_den[j] = r_den[j-1];
        end
        for (int j = 0; j < DV_STEPS; j++) begin
            sh = {in_rem[j], in_low[j][QUO_W-1]};
            ge = sh >= {1'b0, in_den[j]};
            n_rem[j] = ge ? ROOT_W'(sh - {1'b0, in_den[j]}) : ROOT_W'(sh);
            n_low[j] = {in_low[j][QUO_W-2:0], 1'b0};
            n_quo[j] = {in_quo[j][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= DV_NW'({i_mag, {FRAC_W{1'b0}}}) + DV_NW'(i_den >> 1);
            r_den0 <= i_den;
            for (int j = 0; j < DV_STEPS; j++) begin
                r_rem[j] <= n_rem[j];
                r_low[j] <= n_low[j];
                r_quo[j] <= n_quo[j];
                r_den[j] <= in_den[j];
            end
        end
    end

    assign o_quo = r_quo[DV_STEPS-1];

endmodule

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// throughput: one matrix per cycle while the output is not stalled; 4 determinant/select stages, 17 root stages,
// 18 divider stages, one output register
// a stalled output freezes the whole pipeline
// reset: synchronous active low, clears valids and sets det_tolerance to 16
`include "rotation_matrix_to_quaternion_unit_macros.svh"

module rotation_matrix_to_quaternion_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row0_col0,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row0_col1,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row0_col2,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row1_col0,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row1_col1,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row1_col2,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row2_col0,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row2_col1,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_row2_col2,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_quat_z,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_quat_w,
    output logic                                 o_status,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rmq_pkg::TOL_W-1:0]            i_cfg_data
);
    import rmq_pkg::*;

    logic                     w_en;
    t_mat                     w_mat;
    logic [RAD_W-1:0]         w_rad;
    t_side                    w_fside;
    logic [ROOT_W-1:0]        w_root;
    t_dside                   w_dside_in;
    t_dside                   w_dside;
    logic [QUO_W-1:0]         w_quo [3];
    logic signed [DATA_W-1:0] w_n [3];
    logic signed [DATA_W-1:0] w_diag;
    logic signed [DATA_W-1:0] n_qx, n_qy, n_qz, n_qw;
    logic                     n_status;

    logic [TOL_W-1:0]         r_tol;
    logic [LAT-1:0]           r_vld;
    t_side                    r_sq_side [SQ_STEPS];
    t_dside                   r_dv_side [DV_LAT];
    logic                     r_out_v;
    logic signed [DATA_W-1:0] r_qx, r_qy, r_qz, r_qw;
    logic                     r_status;

    assign w_en        = !r_out_v || !i_stall;
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    assign w_mat = '{m00: i_row0_col0, m01: i_row0_col1, m02: i_row0_col2,
                     m10: i_row1_col0, m11: i_row1_col1, m12: i_row1_col2,
                     m20: i_row2_col0, m21: i_row2_col1, m22: i_row2_col2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(TOL_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    rmq_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mat  (w_mat),
        .i_tol  (r_tol),
        .o_rad  (w_rad),
        .o_side (w_fside)
    );

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (w_rad),
        .o_root (w_root)
    );

    always_comb begin
        w_dside_in.ident  = r_sq_side[SQ_STEPS-1].ident;
        w_dside_in.degen  = r_sq_side[SQ_STEPS-1].degen;
        w_dside_in.branch = r_sq_side[SQ_STEPS-1].branch;
        w_dside_in.sgn    = r_sq_side[SQ_STEPS-1].sgn;
        w_dside_in.root   = w_root;
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            rmq_div u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_mag (r_sq_side[SQ_STEPS-1].mag[g]),
                .i_den (w_root),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= w_fside;
            for (int j = 1; j < SQ_STEPS; j++) begin
                r_sq_side[j] <= r_sq_side[j-1];
            end
            r_dv_side[0] <= w_dside_in;
            for (int j = 1; j < DV_LAT; j++) begin
                r_dv_side[j] <= r_dv_side[j-1];
            end
        end
    end

    assign w_dside = r_dv_side[DV_LAT-1];

    // place the diagonal term and the three quotients, then force the identity or degenerate result
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_n[k] = sat_q(w_quo[k], w_dside.sgn[k]);
        end
        w_diag = sat_q(QUO_W'(w_dside.root >> 2), 1'b0);
        unique case (w_dside.branch)
            BR_X: begin
                n_qx = w_diag; n_qy = w_n[0]; n_qz = w_n[1]; n_qw = w_n[2];
            end
            BR_Y: begin
                n_qx = w_n[0]; n_qy = w_diag; n_qz = w_n[1]; n_qw = w_n[2];
            end
            BR_Z: begin
                n_qx = w_n[0]; n_qy = w_n[1]; n_qz = w_diag; n_qw = w_n[2];
            end
            default: begin
                n_qx = w_n[0]; n_qy = w_n[1]; n_qz = w_n[2]; n_qw = w_diag;
            end
        endcase
        n_status = 1'b0;
        if (w_dside.ident) begin
            n_qx = '0; n_qy = '0; n_qz = '0; n_qw = DATA_W'(ONE);
        end else if (w_dside.degen) begin
            n_qx = '0; n_qy = '0; n_qz = '0; n_qw = '0;
            n_status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_vld   <= {r_vld[LAT-2:0], i_valid};
            r_out_v <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qx     <= n_qx;
            r_qy     <= n_qy;
            r_qz     <= n_qz;
            r_qw     <= n_qw;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_out_v;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;
    assign o_status = r_status;

    `RMQ_ASSERT_SAME(a_degen_zero, o_valid && o_status, o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0 && o_quat_w == '0)
    `RMQ_ASSERT_SAME(a_rot_nonzero, o_valid && !o_status, o_quat_x != '0 || o_quat_y != '0 || o_quat_z != '0 || o_quat_w != '0)
    `RMQ_ASSERT_NEXT(a_drain, r_vld[LAT-1] && w_en, o_valid)

endmodule
